[src/tljq_pkg.sv]
// ----------------------------------------------------------------------------
// tljq_pkg
// Shared types and constants of the two-level job queue: item kinds,
// controller command and datapath status groups.
// ----------------------------------------------------------------------------
package tljq_pkg;

    localparam int IMM_DEPTH_DEF = 64;
    localparam int STD_DEPTH_DEF = 64;

    // submit target code for the immediate queue
    localparam logic TARGET_IMM = 1'b1;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_SUBMIT   = 2'd0,
        KIND_TAKE     = 2'd1,
        KIND_PRIO     = 2'd2,
        KIND_COMPLETE = 2'd3
    } kind_t;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic submit;
        logic complete;
        logic take_read;
        logic take_capture;
        logic pr_start;
        logic pr_next_queue;
        logic read_p;
        logic read_front;
        logic save_p;
        logic save_front;
        logic write_front;
        logic write_p;
        logic adv_p;
        logic adv_front;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  imm_empty;
        logic  std_empty;
        logic  cur_imm;
        logic  p_at_end;
        logic  match;
        logic  front_eq_p;
    } status_t;

endpackage

[src/tljq_ram.sv]
// ----------------------------------------------------------------------------
// tljq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tljq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/tljq_ctrl.sv]
// ----------------------------------------------------------------------------
// tljq_ctrl
// Sequencer of the job queue: runs one item at a time through submit, take,
// the prioritize walk and complete, and owns the result valid flag.
// ----------------------------------------------------------------------------
module tljq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  tljq_pkg::status_t sts,
    output tljq_pkg::cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_EXEC   = 8'b0000_0010,
        S_TAKE   = 8'b0000_0100,
        S_PR_ADR = 8'b0000_1000,
        S_PR_CHK = 8'b0001_0000,
        S_PR_FRD = 8'b0010_0000,
        S_PR_W2  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (sts.kind)
                    tljq_pkg::KIND_SUBMIT:
                    begin
                        cmd.submit = 1'b1;
                        state_next = S_DONE;
                    end
                    tljq_pkg::KIND_COMPLETE:
                    begin
                        cmd.complete = 1'b1;
                        state_next   = S_DONE;
                    end
                    tljq_pkg::KIND_TAKE:
                    begin
                        if (sts.imm_empty && sts.std_empty)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.take_read = 1'b1;
                            state_next    = S_TAKE;
                        end
                    end
                    tljq_pkg::KIND_PRIO:
                    begin
                        cmd.pr_start = 1'b1;
                        state_next   = S_PR_ADR;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_TAKE:
            begin
                cmd.take_capture = 1'b1;
                state_next       = S_DONE;
            end
            S_PR_ADR:
            begin
                if (sts.p_at_end)
                begin
                    if (sts.cur_imm)
                    begin
                        cmd.pr_next_queue = 1'b1;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.read_p = 1'b1;
                    state_next = S_PR_CHK;
                end
            end
            S_PR_CHK:
            begin
                if (sts.match && sts.front_eq_p)
                begin
                    cmd.adv_p     = 1'b1;
                    cmd.adv_front = 1'b1;
                    state_next    = S_PR_ADR;
                end
                else if (sts.match)
                begin
                    cmd.save_p     = 1'b1;
                    cmd.read_front = 1'b1;
                    state_next     = S_PR_FRD;
                end
                else
                begin
                    cmd.adv_p  = 1'b1;
                    state_next = S_PR_ADR;
                end
            end
            S_PR_FRD:
            begin
                cmd.save_front  = 1'b1;
                cmd.write_front = 1'b1;
                state_next      = S_PR_W2;
            end
            S_PR_W2:
            begin
                cmd.write_p   = 1'b1;
                cmd.adv_p     = 1'b1;
                cmd.adv_front = 1'b1;
                state_next    = S_PR_ADR;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // an accepted item always starts execution
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_EXEC))
        else $error("accepted item did not start execution");

    // a finished result reaches the output register
    a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!out_valid_reg || !out_stall)) |=> out_valid_reg)
        else $error("finished result not presented");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.load_out)
        else $error("result overwritten while stalled");

endmodule

[src/tljq_dpath.sv]
// ----------------------------------------------------------------------------
// tljq_dpath
// Datapath of the job queue: both descriptor rings, their pointers, the
// outstanding count, the walk pointers and the result registers.
// ----------------------------------------------------------------------------
module tljq_dpath #(
    parameter int IMM_DEPTH = tljq_pkg::IMM_DEPTH_DEF,
    parameter int STD_DEPTH = tljq_pkg::STD_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tljq_pkg::cmd_t    cmd,
    output tljq_pkg::status_t sts,
    input  logic [1:0]        kind,
    input  logic              to_immediate,
    input  logic [15:0]       job_type,
    input  logic [47:0]       job_handle,
    input  logic [15:0]       prio_type,
    output logic              accepted,
    output logic              run_inline,
    output logic              found,
    output logic              from_immediate,
    output logic [15:0]       out_job_type,
    output logic [47:0]       out_job_handle,
    output logic [5:0]        imm_count,
    output logic [5:0]        std_count,
    output logic [15:0]       outstanding,
    output logic              all_done
);

    localparam int AWI = $clog2(IMM_DEPTH);
    localparam int AWS = $clog2(STD_DEPTH);
    localparam int PW  = (AWI > AWS) ? AWI : AWS;
    localparam int CW  = PW + 7;

    // latched item
    tljq_pkg::kind_t kind_reg;
    logic            to_imm_reg;
    logic [15:0]     type_reg;
    logic [47:0]     handle_reg;
    logic [15:0]     ptype_reg;

    // ring pointers and count
    logic [AWI-1:0] imm_wr_reg, imm_rd_reg;
    logic [AWS-1:0] std_wr_reg, std_rd_reg;
    logic [15:0]    outst_reg;

    // walk state
    logic           cur_imm_reg;
    logic [PW-1:0]  p_reg, front_reg;
    logic [63:0]    ep_reg, ef_reg;

    // working result
    logic        res_acc_reg, res_inl_reg, res_fnd_reg, res_fim_reg;
    logic [63:0] res_job_reg;

    // output registers
    logic        o_acc_reg, o_inl_reg, o_fnd_reg, o_fim_reg, o_done_reg;
    logic [63:0] o_job_reg;
    logic [5:0]  o_ic_reg, o_sc_reg;
    logic [15:0] o_out_reg;

    // ring status
    logic [AWI-1:0] imm_wr_nx, imm_rd_nx;
    logic [AWS-1:0] std_wr_nx, std_rd_nx;
    logic           imm_empty, std_empty, imm_full, std_full;
    logic [CW-1:0]  imm_cnt, std_cnt;

    assign imm_wr_nx = (imm_wr_reg == AWI'(IMM_DEPTH - 1)) ? '0 : imm_wr_reg + 1'b1;
    assign imm_rd_nx = (imm_rd_reg == AWI'(IMM_DEPTH - 1)) ? '0 : imm_rd_reg + 1'b1;
    assign std_wr_nx = (std_wr_reg == AWS'(STD_DEPTH - 1)) ? '0 : std_wr_reg + 1'b1;
    assign std_rd_nx = (std_rd_reg == AWS'(STD_DEPTH - 1)) ? '0 : std_rd_reg + 1'b1;
    assign imm_empty = (imm_wr_reg == imm_rd_reg);
    assign std_empty = (std_wr_reg == std_rd_reg);
    assign imm_full  = (imm_wr_nx == imm_rd_reg);
    assign std_full  = (std_wr_nx == std_rd_reg);

    // queue fill counts
    always_comb
    begin
        if (imm_wr_reg >= imm_rd_reg)
        begin
            imm_cnt = CW'(imm_wr_reg) - CW'(imm_rd_reg);
        end
        else
        begin
            imm_cnt = CW'(imm_wr_reg) + CW'(IMM_DEPTH) - CW'(imm_rd_reg);
        end
        if (std_wr_reg >= std_rd_reg)
        begin
            std_cnt = CW'(std_wr_reg) - CW'(std_rd_reg);
        end
        else
        begin
            std_cnt = CW'(std_wr_reg) + CW'(STD_DEPTH) - CW'(std_rd_reg);
        end
    end

    // walk pointer stepping in the current ring
    logic [PW-1:0] p_nx, front_nx, cur_wr;
    always_comb
    begin
        if (cur_imm_reg)
        begin
            p_nx     = (p_reg == PW'(IMM_DEPTH - 1)) ? '0 : p_reg + 1'b1;
            front_nx = (front_reg == PW'(IMM_DEPTH - 1)) ? '0 : front_reg + 1'b1;
            cur_wr   = PW'(imm_wr_reg);
        end
        else
        begin
            p_nx     = (p_reg == PW'(STD_DEPTH - 1)) ? '0 : p_reg + 1'b1;
            front_nx = (front_reg == PW'(STD_DEPTH - 1)) ? '0 : front_reg + 1'b1;
            cur_wr   = PW'(std_wr_reg);
        end
    end

    // ram ports
    logic           imm_we, std_we;
    logic [PW-1:0]  waddr, raddr;
    logic [63:0]    wdata, imm_q, std_q, rdata;

    always_comb
    begin
        imm_we = 1'b0;
        std_we = 1'b0;
        waddr  = p_reg;
        wdata  = ef_reg;
        raddr  = p_reg;
        if (cmd.submit)
        begin
            if (to_imm_reg == tljq_pkg::TARGET_IMM)
            begin
                imm_we = !imm_full;
                waddr  = PW'(imm_wr_reg);
            end
            else
            begin
                std_we = !std_full;
                waddr  = PW'(std_wr_reg);
            end
            wdata = {type_reg, handle_reg};
        end
        else if (cmd.write_front || cmd.write_p)
        begin
            imm_we = cur_imm_reg;
            std_we = !cur_imm_reg;
            waddr  = cmd.write_front ? front_reg : p_reg;
            wdata  = cmd.write_front ? ep_reg : ef_reg;
        end
        if (cmd.take_read)
        begin
            raddr = imm_empty ? PW'(std_rd_reg) : PW'(imm_rd_reg);
        end
        else if (cmd.read_front)
        begin
            raddr = front_reg;
        end
    end

    tljq_ram #(.WIDTH(64), .DEPTH(IMM_DEPTH)) u_imm_ram (
        .clk   (clk),
        .we    (imm_we),
        .waddr (waddr[AWI-1:0]),
        .wdata (wdata),
        .raddr (raddr[AWI-1:0]),
        .rdata (imm_q)
    );

    tljq_ram #(.WIDTH(64), .DEPTH(STD_DEPTH)) u_std_ram (
        .clk   (clk),
        .we    (std_we),
        .waddr (waddr[AWS-1:0]),
        .wdata (wdata),
        .raddr (raddr[AWS-1:0]),
        .rdata (std_q)
    );

    assign rdata = cur_imm_reg ? imm_q : std_q;

    // status toward the controller
    assign sts.kind       = kind_reg;
    assign sts.imm_empty  = imm_empty;
    assign sts.std_empty  = std_empty;
    assign sts.cur_imm    = cur_imm_reg;
    assign sts.p_at_end   = (p_reg == cur_wr);
    assign sts.match      = (rdata[63:48] == ptype_reg);
    assign sts.front_eq_p = (front_reg == p_reg);

    // control registers: pointers and outstanding count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            imm_wr_reg <= '0;
            imm_rd_reg <= '0;
            std_wr_reg <= '0;
            std_rd_reg <= '0;
            outst_reg  <= '0;
        end
        else
        begin
            if (imm_we && cmd.submit)
            begin
                imm_wr_reg <= imm_wr_nx;
            end
            if (std_we && cmd.submit)
            begin
                std_wr_reg <= std_wr_nx;
            end
            if (cmd.take_capture && cur_imm_reg)
            begin
                imm_rd_reg <= imm_rd_nx;
            end
            if (cmd.take_capture && !cur_imm_reg)
            begin
                std_rd_reg <= std_rd_nx;
            end
            if (cmd.submit && outst_reg != tljq_pkg::COUNT_MAX)
            begin
                outst_reg <= outst_reg + 16'd1;
            end
            else if (cmd.complete && outst_reg != 16'd0)
            begin
                outst_reg <= outst_reg - 16'd1;
            end
        end
    end

    // item latch, walk and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg    <= tljq_pkg::kind_t'(kind);
            to_imm_reg  <= to_immediate;
            type_reg    <= job_type;
            handle_reg  <= job_handle;
            ptype_reg   <= prio_type;
            res_acc_reg <= 1'b0;
            res_inl_reg <= 1'b0;
            res_fnd_reg <= 1'b0;
            res_fim_reg <= 1'b0;
            res_job_reg <= '0;
        end
        if (cmd.submit)
        begin
            res_acc_reg <= imm_we || std_we;
            res_inl_reg <= !(imm_we || std_we);
        end
        if (cmd.take_read)
        begin
            cur_imm_reg <= !imm_empty;
        end
        if (cmd.take_capture)
        begin
            res_fnd_reg <= 1'b1;
            res_fim_reg <= cur_imm_reg;
            res_job_reg <= rdata;
        end
        if (cmd.pr_start)
        begin
            cur_imm_reg <= 1'b1;
            p_reg       <= PW'(imm_rd_reg);
            front_reg   <= PW'(imm_rd_reg);
        end
        if (cmd.pr_next_queue)
        begin
            cur_imm_reg <= 1'b0;
            p_reg       <= PW'(std_rd_reg);
            front_reg   <= PW'(std_rd_reg);
        end
        if (cmd.save_p)
        begin
            ep_reg <= rdata;
        end
        if (cmd.save_front)
        begin
            ef_reg <= rdata;
        end
        if (cmd.adv_p)
        begin
            p_reg <= p_nx;
        end
        if (cmd.adv_front)
        begin
            front_reg <= front_nx;
        end
        if (cmd.load_out)
        begin
            o_acc_reg  <= res_acc_reg;
            o_inl_reg  <= res_inl_reg;
            o_fnd_reg  <= res_fnd_reg;
            o_fim_reg  <= res_fim_reg;
            o_job_reg  <= res_job_reg;
            o_ic_reg   <= imm_cnt[5:0];
            o_sc_reg   <= std_cnt[5:0];
            o_out_reg  <= outst_reg;
            o_done_reg <= imm_empty && std_empty && (outst_reg == 16'd0);
        end
    end

    assign accepted       = o_acc_reg;
    assign run_inline     = o_inl_reg;
    assign found          = o_fnd_reg;
    assign from_immediate = o_fim_reg;
    assign out_job_type   = o_job_reg[63:48];
    assign out_job_handle = o_job_reg[47:0];
    assign imm_count      = o_ic_reg;
    assign std_count      = o_sc_reg;
    assign outstanding    = o_out_reg;
    assign all_done       = o_done_reg;

endmodule

[src/two_level_job_queue.sv]
// ----------------------------------------------------------------------------
// two_level_job_queue
// Strict priority pair of ring queues of job descriptors with submit, take,
// prioritize-by-type and completion tracking.
//
//   channel | signals                                         | direction
//   in      | in_valid, in_stall, kind .. prio_type           | into block
//   out     | out_valid, out_stall, accepted .. all_done      | out of block
//
// One item at a time. A take makes one ram read, or none when both queues
// are empty; a prioritize walks every job of both rings and swaps each
// matching job not already at the walk front, the walk cost being set by
// the single read and write port of each ring ram.
// in_stall is high from acceptance until the result is in the output
// register; a stalled result holds there while the next item is accepted,
// and a result still waiting adds its stall cycles to the following item.
// Reset clears the pointers and the outstanding count; ram needs no clearing.
// ----------------------------------------------------------------------------
module two_level_job_queue #(
    parameter int IMM_DEPTH = tljq_pkg::IMM_DEPTH_DEF,
    parameter int STD_DEPTH = tljq_pkg::STD_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic        to_immediate,
    input  logic [15:0] job_type,
    input  logic [47:0] job_handle,
    input  logic [15:0] prio_type,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic        run_inline,
    output logic        found,
    output logic        from_immediate,
    output logic [15:0] out_job_type,
    output logic [47:0] out_job_handle,
    output logic [5:0]  imm_count,
    output logic [5:0]  std_count,
    output logic [15:0] outstanding,
    output logic        all_done
);

    tljq_pkg::cmd_t    cmd;
    tljq_pkg::status_t sts;

    // sequencer
    tljq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // rings, counters and result registers
    tljq_dpath #(
        .IMM_DEPTH (IMM_DEPTH),
        .STD_DEPTH (STD_DEPTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .kind           (kind),
        .to_immediate   (to_immediate),
        .job_type       (job_type),
        .job_handle     (job_handle),
        .prio_type      (prio_type),
        .accepted       (accepted),
        .run_inline     (run_inline),
        .found          (found),
        .from_immediate (from_immediate),
        .out_job_type   (out_job_type),
        .out_job_handle (out_job_handle),
        .imm_count      (imm_count),
        .std_count      (std_count),
        .outstanding    (outstanding),
        .all_done       (all_done)
    );

endmodule

[tb/two_level_job_queue_tb.sv]
// ----------------------------------------------------------------------------
// two_level_job_queue_tb
// Self-checking bench for the two-level job queue. A scoreboard class keeps
// its own copy of both rings and the outstanding count, predicts the result
// of every accepted transfer and checks results in order. Stimulus is a
// directed set of corner cases followed by random traffic with bursts of
// idling on both sides, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module two_level_job_queue_tb;

    localparam int QDEPTH = 64;

    typedef struct packed {
        logic        accepted;
        logic        run_inline;
        logic        found;
        logic        from_immediate;
        logic [15:0] job_type;
        logic [47:0] job_handle;
        logic [5:0]  imm_count;
        logic [5:0]  std_count;
        logic [15:0] outstanding;
        logic        all_done;
    } job_result_t;

    // queue model and result checker
    class job_queue_scoreboard;
        logic [63:0] imm_ring[QDEPTH];
        logic [63:0] std_ring[QDEPTH];
        int imm_wr, imm_rd, std_wr, std_rd;
        logic [15:0] pending;
        job_result_t due[$];
        int mismatches;

        function new();
            imm_wr = 0; imm_rd = 0; std_wr = 0; std_rd = 0;
            pending = 0; mismatches = 0;
        endfunction

        function int fill(bit imm);
            if (imm)
                return (imm_wr + QDEPTH - imm_rd) % QDEPTH;
            return (std_wr + QDEPTH - std_rd) % QDEPTH;
        endfunction

        // move matching jobs to the front, keeping their order
        function void promote(bit imm, logic [15:0] ptype);
            int front;
            int p;
            int wr;
            logic [63:0] t;
            front = imm ? imm_rd : std_rd;
            wr = imm ? imm_wr : std_wr;
            for (p = front; p != wr; p = (p + 1) % QDEPTH)
            begin
                if (imm)
                begin
                    if (imm_ring[p][63:48] == ptype)
                    begin
                        t = imm_ring[front]; imm_ring[front] = imm_ring[p];
                        imm_ring[p] = t; front = (front + 1) % QDEPTH;
                    end
                end
                else if (std_ring[p][63:48] == ptype)
                begin
                    t = std_ring[front]; std_ring[front] = std_ring[p];
                    std_ring[p] = t; front = (front + 1) % QDEPTH;
                end
            end
        endfunction

        function void note_transfer(tljq_pkg::kind_t k, logic imm, logic [15:0] jt,
                                    logic [47:0] jh, logic [15:0] pt);
            job_result_t r;
            logic [63:0] e;
            int ic;
            int sc;
            r = '{default: 0};
            case (k)
                tljq_pkg::KIND_SUBMIT:
                begin
                    if (imm == tljq_pkg::TARGET_IMM)
                    begin
                        if ((imm_wr + 1) % QDEPTH == imm_rd) r.run_inline = 1;
                        else
                        begin
                            imm_ring[imm_wr] = {jt, jh};
                            imm_wr = (imm_wr + 1) % QDEPTH; r.accepted = 1;
                        end
                    end
                    else if ((std_wr + 1) % QDEPTH == std_rd) r.run_inline = 1;
                    else
                    begin
                        std_ring[std_wr] = {jt, jh};
                        std_wr = (std_wr + 1) % QDEPTH; r.accepted = 1;
                    end
                    if (pending != tljq_pkg::COUNT_MAX) pending++;
                end
                tljq_pkg::KIND_TAKE:
                begin
                    if (imm_wr != imm_rd)
                    begin
                        e = imm_ring[imm_rd]; imm_rd = (imm_rd + 1) % QDEPTH;
                        r.found = 1; r.from_immediate = 1;
                    end
                    else if (std_wr != std_rd)
                    begin
                        e = std_ring[std_rd]; std_rd = (std_rd + 1) % QDEPTH;
                        r.found = 1;
                    end
                    if (r.found)
                    begin
                        r.job_type = e[63:48]; r.job_handle = e[47:0];
                    end
                end
                tljq_pkg::KIND_PRIO:
                begin
                    promote(1, pt);
                    promote(0, pt);
                end
                default:
                    if (pending != 0) pending--;
            endcase
            ic = fill(1); sc = fill(0);
            r.imm_count = ic[5:0]; r.std_count = sc[5:0];
            r.outstanding = pending;
            r.all_done = (ic == 0 && sc == 0 && pending == 0);
            due.push_back(r);
        endfunction

        function void check_result(job_result_t got);
            job_result_t w;
            if (due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("result with nothing expected");
                return;
            end
            w = due.pop_front();
            if (got !== w)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: exp acc%0b inl%0b fnd%0b imm%0b t%h h%h ic%0d sc%0d o%0d d%0b",
                        w.accepted, w.run_inline, w.found, w.from_immediate,
                        w.job_type, w.job_handle, w.imm_count, w.std_count,
                        w.outstanding, w.all_done);
                    $display("          got acc%0b inl%0b fnd%0b imm%0b t%h h%h ic%0d sc%0d o%0d d%0b",
                        got.accepted, got.run_inline, got.found,
                        got.from_immediate, got.job_type, got.job_handle,
                        got.imm_count, got.std_count, got.outstanding,
                        got.all_done);
                end
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  kind = 0;
    logic        to_immediate = 0;
    logic [15:0] job_type = 0;
    logic [47:0] job_handle = 0;
    logic [15:0] prio_type = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic        accepted, run_inline, found, from_immediate, all_done;
    logic [15:0] out_job_type, outstanding;
    logic [47:0] out_job_handle;
    logic [5:0]  imm_count, std_count;

    job_queue_scoreboard sb = new();
    bit calm = 0;
    bit hold_off = 0;
    bit hold_done = 0;
    int sent = 0;

    two_level_job_queue u_top (.*);

    always #4 clk = ~clk;

    // sample both channels at each rising edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_transfer(tljq_pkg::kind_t'(kind), to_immediate, job_type,
                             job_handle, prio_type);
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{accepted, run_inline, found, from_immediate,
                out_job_type, out_job_handle, imm_count, std_count,
                outstanding, all_done});
    end

    // receiver: random stall bursts, one long hold-off
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off && !hold_done)
            begin
                out_stall <= 1;
                repeat (300) @(posedge clk);
                hold_done = 1;
                out_stall <= 0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 11);
                out_stall <= 1;
                repeat (n) @(posedge clk);
                out_stall <= 0;
            end
        end
    end

    // offer one item and wait until it is taken; valid stays up afterward
    task automatic send_item(tljq_pkg::kind_t k, logic imm, logic [15:0] jt,
                             logic [47:0] jh, logic [15:0] pt);
        int n;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 11);
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1; kind <= k; to_immediate <= imm;
        job_type <= jt; job_handle <= jh; prio_type <= pt;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    // stop offering right after the last transfer
    task automatic stop_input();
        in_valid <= 0;
    endtask

    task automatic send_random(int count);
        int i;
        int r;
        tljq_pkg::kind_t k;
        for (i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            k = r < 45 ? tljq_pkg::KIND_SUBMIT :
                r < 80 ? tljq_pkg::KIND_TAKE :
                r < 88 ? tljq_pkg::KIND_PRIO : tljq_pkg::KIND_COMPLETE;
            send_item(k, 1'($urandom_range(0, 1)),
                {12'h0, 4'($urandom_range(0, 7))} ^
                    (($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'h0),
                {16'($urandom), 32'($urandom)},
                16'($urandom_range(0, 7)));
        end
    endtask

    task automatic drain();
        stop_input();
        while (sb.due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        int i;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed corners
        send_item(tljq_pkg::KIND_TAKE, 0, 0, 0, 0);
        send_item(tljq_pkg::KIND_COMPLETE, 0, 0, 0, 0);
        send_item(tljq_pkg::KIND_SUBMIT, 1, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 0);
        send_item(tljq_pkg::KIND_SUBMIT, 0, 16'h0000, 48'h0, 0);
        send_item(tljq_pkg::KIND_SUBMIT, 0, 16'h0005, 48'h1234_5678_9ABC, 0);
        send_item(tljq_pkg::KIND_SUBMIT, 1, 16'h0005, 48'hA5A5_5A5A_A5A5, 0);
        send_item(tljq_pkg::KIND_PRIO, 0, 0, 0, 16'h0005);
        send_item(tljq_pkg::KIND_PRIO, 0, 0, 0, 16'hFFFF);
        for (i = 0; i < 5; i++)
            send_item(tljq_pkg::KIND_TAKE, 0, 0, 0, 0);
        for (i = 0; i < 6; i++)
            send_item(tljq_pkg::KIND_COMPLETE, 0, 0, 0, 0);
        // fill the immediate queue past full, then prioritize a full ring
        for (i = 0; i < 66; i++)
            send_item(tljq_pkg::KIND_SUBMIT, 1, 16'(i % 3), 48'(i), 0);
        send_item(tljq_pkg::KIND_PRIO, 0, 0, 0, 16'd2);
        drain();
        send_random(400);
        // long output hold-off while input keeps coming
        hold_off = 1;
        send_random(40);
        stop_input();
        wait (hold_done);
        send_random(300);
        drain();
        // a burst of standard submits
        for (i = 0; i < 20; i++)
            send_item(tljq_pkg::KIND_SUBMIT, 0, 0, 0, 0);
        send_random(300);
        calm = 1;
        send_random(100);
        drain();
        if (sb.mismatches == 0)
            $display("two_level_job_queue_tb: done, clean");
        else
            $display("two_level_job_queue_tb: done, errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("two_level_job_queue_tb: done, errors");
        $finish;
    end

endmodule

[sim.f]
src/tljq_pkg.sv
src/tljq_ram.sv
src/tljq_ctrl.sv
src/tljq_dpath.sv
src/two_level_job_queue.sv
tb/two_level_job_queue_tb.sv
